// ----- rtl/core/pvram_pkg.sv -----
// ----------------------------------------------------------------------------
// pvram_pkg: shared types and constants for the planar graphics memory port
// Holds the beat structs, command codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pvram_pkg;

    localparam int MemBytes = 262144;

    typedef enum logic [1:0] {
        CMD_BYTE_READ  = 2'd0,
        CMD_BYTE_WRITE = 2'd1,
        CMD_WORD_READ  = 2'd2,
        CMD_WORD_WRITE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [17:0] address;
        logic [15:0] write_data;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [3:0]  wait_cycles;
    } out_beat_t;

    localparam logic [2:0] REG_ACCESS_CONTROL = 3'd0;
    localparam logic [2:0] REG_PLANE_MASKS    = 3'd1;
    localparam logic [2:0] REG_ADVANCED_MODE  = 3'd2;
    localparam logic [2:0] REG_SINGLE_WRITE   = 3'd3;
    localparam logic [2:0] REG_PLANE_ROPS     = 3'd4;
    localparam logic [2:0] REG_COMPARE_DATA   = 3'd5;
    localparam logic [2:0] REG_PAGE_SETUP     = 3'd6;

    localparam logic [1:0] SRC_LOGIC = 2'd0;
    localparam logic [1:0] SRC_PAT   = 2'd1;
    localparam logic [1:0] SRC_CPU   = 2'd2;
    localparam logic [1:0] SRC_MEM   = 2'd3;

    typedef struct packed {
        logic [2:0]  access_control;
        logic [7:0]  plane_masks;
        logic [7:0]  advanced_mode;
        logic [1:0]  single_write_mode;
        logic [31:0] plane_rops;
        logic [31:0] compare_data;
        logic [47:0] single_page_setup;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_WAIT,
        ST_RD_DATA,
        ST_WR_ADDR,
        ST_WR_WAIT,
        ST_WR_DATA,
        ST_NEXT,
        ST_OUT
    } state_t;

    // Logic unit: bit (pat*4 + cpu*2 + mem) of the rop byte, per bit lane
    function automatic logic [7:0] rop8(input logic [7:0] rop, input logic [7:0] pat,
                                       input logic [7:0] cpu, input logic [7:0] mem);
        logic [7:0] r;
        r = '0;
        for (int b = 0; b < 8; b++) begin
            r[b] = rop[{pat[b], cpu[b], mem[b]}];
        end
        return r;
    endfunction

    function automatic logic [7:0] pick8(input logic [1:0] sel, input logic [7:0] rop,
                                        input logic [7:0] pat, input logic [7:0] cpu,
                                        input logic [7:0] mem);
        logic [7:0] r;
        unique case (sel)
            SRC_LOGIC: r = rop8(rop, pat, cpu, mem);
            SRC_PAT:   r = pat;
            SRC_CPU:   r = cpu;
            default:   r = mem;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/planar_vram_raster_op_access_core.sv -----
// ----------------------------------------------------------------------------
// planar_vram_raster_op_access_core: planar graphics memory port
// Byte and word reads and writes with raster ops, plane masks and patterns.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in      | in        | command, address, write_data
//  out     | out       | read_data, wait_cycles
//  apb     | in/out    | configuration registers at 8*i
//
//  Each item is broken into byte steps on the single memory port: a step
//  passes through the address, wait, data and advance states for each plane
//  of each byte, read or read-modify-write; a masked plane goes from address
//  straight to advance. An item is accepted in idle and ends in the result state.
//  After reset a clearing pass zeroes every byte of the memory; no item
//  is taken meanwhile. A result waits in an output register while out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_vram_raster_op_access_core #(
    parameter int MEMORY_BYTES = pvram_pkg::MemBytes
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire pvram_pkg::in_beat_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pvram_pkg::out_beat_t      out_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [5:0]           paddr,
    input  wire logic [63:0]          pwdata,
    output logic      [63:0]          prdata,
    output logic                      pready
);
    import pvram_pkg::*;

    localparam int AW = $clog2(MEMORY_BYTES);

    cfg_t cfg;

    pvram_cfg_regs u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
    );
    assign pready = 1'b1;

    logic          m_we;
    logic [AW-1:0] m_addr;
    logic [7:0]    m_wdata;
    logic [7:0]    m_rdata;

    pvram_mem #(.MEMORY_BYTES(MEMORY_BYTES)) u_mem (
        .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
    );

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [15:0]   data_reg, data_next;
    logic          second_reg, second_next;   // working on the second byte
    logic [1:0]    plane_reg, plane_next;
    logic [7:0]    acc_reg, acc_next;          // AND / compare accumulator
    logic [7:0]    lo_reg, lo_next;
    logic [7:0]    pat_reg [8];
    logic [7:0]    pat_next [8];
    logic [3:0]    rsel_reg, rsel_next, wsel_reg, wsel_next;
    logic          ovalid_reg, ovalid_next;
    out_beat_t     obeat_reg, obeat_next;

    // Per-step decode
    logic          single, ext, multi, is_read, word, odd;
    logic [AW-1:0] byte_addr, mem_a;
    logic [15:0]   plane_off;
    logic [7:0]    cpu_byte, sp_rop, sp_pat, wr_val, p_rop, p_pat, cmp;
    logic          plane_off_mask;
    logic [3:0]    wait_rd, wait_wr;

    always_comb begin
        single    = cfg.access_control[0];
        ext       = !single && cfg.access_control[1];
        multi     = !single;
        is_read   = !cmd_reg[0];
        word      = cmd_reg[1];
        odd       = addr_reg[0];
        byte_addr = addr_reg + AW'(second_reg);
        plane_off = {cfg.access_control[2], byte_addr[14:0]};
        mem_a     = ext ? AW'({plane_reg, plane_off}) : byte_addr;
        if (word && second_reg) cpu_byte = data_reg[15:8];
        else                    cpu_byte = data_reg[7:0];
        // single-plane: page from the top address bit, lane from byte address bit 0
        sp_rop = cfg.single_page_setup[8*byte_addr[AW-1] +: 8];
        sp_pat = cfg.single_page_setup[16 + 16*byte_addr[AW-1] + 8*byte_addr[0] +: 8];
        p_rop  = cfg.plane_rops[8*plane_reg +: 8];
        p_pat  = pat_reg[{plane_reg, rsel_reg[plane_reg]}];
        cmp    = cfg.compare_data[8*plane_reg +: 8];
        plane_off_mask = is_read ? cfg.plane_masks[4 + plane_reg] : cfg.plane_masks[plane_reg];
        if (single)
            wr_val = pick8(cfg.single_write_mode, sp_rop, sp_pat, cpu_byte, m_rdata);
        else if (ext)
            wr_val = pick8(cfg.advanced_mode[4:3], p_rop, p_pat, cpu_byte, m_rdata);
        else
            wr_val = cpu_byte;
        wait_rd = multi ? 4'd7 : 4'd4;
        wait_wr = multi ? 4'd4 : 4'd1;
    end

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cmd_next    = cmd_reg;
        addr_next   = addr_reg;
        data_next   = data_reg;
        second_next = second_reg;
        plane_next  = plane_reg;
        acc_next    = acc_reg;
        lo_next     = lo_reg;
        for (int i = 0; i < 8; i++) pat_next[i] = pat_reg[i];
        rsel_next   = rsel_reg;
        wsel_next   = wsel_reg;
        ovalid_next = ovalid_reg && out_stall;
        obeat_next  = obeat_reg;
        m_we        = 1'b0;
        m_addr      = mem_a;
        m_wdata     = wr_val;
        in_stall    = 1'b1;

        unique case (state_reg)
            ST_CLEAR: begin
                m_we     = 1'b1;
                m_addr   = clr_reg;
                m_wdata  = 8'd0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MEMORY_BYTES - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                in_stall = 1'b0;
                if (in_valid) begin
                    cmd_next    = in_data.command;
                    addr_next   = in_data.address[AW-1:0];
                    data_next   = in_data.write_data;
                    second_next = 1'b0;
                    plane_next  = 2'd0;
                    acc_next    = 8'hff;
                    state_next  = in_data.command[0] ? ST_WR_ADDR : ST_RD_ADDR;
                end
            end
            // read: skip masked planes in extended mode
            ST_RD_ADDR: begin
                if (ext && plane_off_mask) state_next = ST_NEXT;
                else                       state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT: state_next = ST_RD_DATA;
            ST_RD_DATA: begin
                if (ext) begin
                    if (cfg.advanced_mode[5]) acc_next = acc_reg & ~(m_rdata ^ cmp);
                    else                      acc_next = acc_reg & m_rdata;
                    if (cfg.advanced_mode[0])
                        pat_next[{plane_reg, wsel_reg[plane_reg]}] = m_rdata;
                end else begin
                    acc_next = m_rdata;
                end
                state_next = ST_NEXT;
            end
            ST_WR_ADDR: begin
                if (ext && plane_off_mask) state_next = ST_NEXT;
                else                       state_next = ST_WR_WAIT;
            end
            ST_WR_WAIT: state_next = ST_WR_DATA;
            ST_WR_DATA: begin
                m_we = 1'b1;
                if (ext && cfg.advanced_mode[1])
                    pat_next[{plane_reg, wsel_reg[plane_reg]}] = m_rdata;
                state_next = ST_NEXT;
            end
            // advance plane, then byte, then finish
            ST_NEXT: begin
                if (ext && plane_reg != 2'd3) begin
                    plane_next = plane_reg + 2'd1;
                    state_next = is_read ? ST_RD_ADDR : ST_WR_ADDR;
                end else begin
                    plane_next = 2'd0;
                    if (ext && cfg.advanced_mode[2]) begin
                        if (is_read) begin
                            if (cfg.advanced_mode[0]) wsel_next = ~wsel_reg;
                        end else begin
                            rsel_next = ~rsel_reg;
                            if (cfg.advanced_mode[1]) wsel_next = ~wsel_reg;
                        end
                    end
                    if (word && !second_reg) begin
                        second_next = 1'b1;
                        lo_next     = acc_reg;
                        acc_next    = 8'hff;
                        state_next  = is_read ? ST_RD_ADDR : ST_WR_ADDR;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!ovalid_reg || !out_stall) begin
                    ovalid_next = 1'b1;
                    if (is_read)
                        obeat_next.read_data = word ? {acc_reg, lo_reg} : {8'd0, acc_reg};
                    else
                        obeat_next.read_data = 16'd0;
                    if (is_read)                  obeat_next.wait_cycles = wait_rd;
                    else if (word && odd)         obeat_next.wait_cycles = wait_wr << 1;
                    else                          obeat_next.wait_cycles = wait_wr;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            rsel_reg   <= '0;
            wsel_reg   <= '0;
            for (int i = 0; i < 8; i++) pat_reg[i] <= '0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            rsel_reg   <= rsel_next;
            wsel_reg   <= wsel_next;
            for (int i = 0; i < 8; i++) pat_reg[i] <= pat_next[i];
        end
    end

    // Payload registers
    always_ff @(posedge clk) begin
        cmd_reg    <= cmd_next;
        addr_reg   <= addr_next;
        data_reg   <= data_next;
        second_reg <= second_next;
        plane_reg  <= plane_next;
        acc_reg    <= acc_next;
        lo_reg     <= lo_next;
        obeat_reg  <= obeat_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = obeat_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pvram_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pvram_cfg_regs: configuration register file
// APB-style write and read of the seven control registers at 8-byte spacing.
// ----------------------------------------------------------------------------
`default_nettype none

module pvram_cfg_regs (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [5:0]            paddr,
    input  wire logic [63:0]           pwdata,
    output logic      [63:0]           prdata,
    output pvram_pkg::cfg_t            cfg
);
    import pvram_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx   = paddr[5:3];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    // Capture register writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_ACCESS_CONTROL: cfg_reg.access_control    <= pwdata[2:0];
                REG_PLANE_MASKS:    cfg_reg.plane_masks       <= pwdata[7:0];
                REG_ADVANCED_MODE:  cfg_reg.advanced_mode     <= pwdata[7:0];
                REG_SINGLE_WRITE:   cfg_reg.single_write_mode <= pwdata[1:0];
                REG_PLANE_ROPS:     cfg_reg.plane_rops        <= pwdata[31:0];
                REG_COMPARE_DATA:   cfg_reg.compare_data      <= pwdata[31:0];
                REG_PAGE_SETUP:     cfg_reg.single_page_setup <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        unique case (idx)
            REG_ACCESS_CONTROL: prdata = {61'd0, cfg_reg.access_control};
            REG_PLANE_MASKS:    prdata = {56'd0, cfg_reg.plane_masks};
            REG_ADVANCED_MODE:  prdata = {56'd0, cfg_reg.advanced_mode};
            REG_SINGLE_WRITE:   prdata = {62'd0, cfg_reg.single_write_mode};
            REG_PLANE_ROPS:     prdata = {32'd0, cfg_reg.plane_rops};
            REG_COMPARE_DATA:   prdata = {32'd0, cfg_reg.compare_data};
            REG_PAGE_SETUP:     prdata = {16'd0, cfg_reg.single_page_setup};
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/pvram_mem.sv -----
// ----------------------------------------------------------------------------
// pvram_mem: graphics byte memory
// One port, one byte read or written per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pvram_mem #(
    parameter int MEMORY_BYTES = pvram_pkg::MemBytes
) (
    input  wire logic                            clk,
    input  wire logic                            we,
    input  wire logic [$clog2(MEMORY_BYTES)-1:0] addr,
    input  wire logic [7:0]                      wdata,
    output logic      [7:0]                      rdata
);
    logic [7:0] mem [MEMORY_BYTES];

    // Write or read one byte
    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- tb/tb_planar_vram_raster_op_access_core.sv -----
// ----------------------------------------------------------------------------
// tb_planar_vram_raster_op_access_core: planar graphics memory port testbench
// Runs directed and random byte/word reads and writes under several register
// settings. The scoreboard keeps a mirror of the memory, the plane patterns
// and the register file, and predicts the read data and wait count of every
// beat. Each result beat is checked in order against that prediction.
// ----------------------------------------------------------------------------
`default_nettype none

class vram_scoreboard;
    logic [7:0]  mem [0:262143];
    logic [7:0]  pats [0:7];
    logic [3:0]  rd_sel;
    logic [3:0]  wr_sel;
    pvram_pkg::cfg_t cfg;
    pvram_pkg::out_beat_t pending [$];
    int errors;

    function new();
        for (int i = 0; i < 262144; i++) mem[i] = 8'h00;
        for (int i = 0; i < 8; i++) pats[i] = 8'h00;
        rd_sel = '0;
        wr_sel = '0;
        cfg = '0;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] v);
        case (idx)
            pvram_pkg::REG_ACCESS_CONTROL: cfg.access_control = v[2:0];
            pvram_pkg::REG_PLANE_MASKS:    cfg.plane_masks = v[7:0];
            pvram_pkg::REG_ADVANCED_MODE:  cfg.advanced_mode = v[7:0];
            pvram_pkg::REG_SINGLE_WRITE:   cfg.single_write_mode = v[1:0];
            pvram_pkg::REG_PLANE_ROPS:     cfg.plane_rops = v[31:0];
            pvram_pkg::REG_COMPARE_DATA:   cfg.compare_data = v[31:0];
            pvram_pkg::REG_PAGE_SETUP:     cfg.single_page_setup = v[47:0];
            default: ;
        endcase
    endfunction

    function logic [15:0] raster(logic [7:0] rop, logic [15:0] p, logic [15:0] c,
                                 logic [15:0] m);
        logic [15:0] r;
        for (int b = 0; b < 16; b++) r[b] = rop[{p[b], c[b], m[b]}];
        return r;
    endfunction

    function logic [15:0] choose(logic [1:0] sel, logic [7:0] rop, logic [15:0] p,
                                 logic [15:0] c, logic [15:0] m);
        case (sel)
            pvram_pkg::SRC_LOGIC: return raster(rop, p, c, m);
            pvram_pkg::SRC_PAT:   return p;
            pvram_pkg::SRC_CPU:   return c;
            default:              return m;
        endcase
    endfunction

    // Combine a word at an even address with the per-page rop and pattern
    function logic [15:0] page_word(logic [17:0] a, logic [15:0] d);
        logic [15:0] m;
        logic [7:0]  rop;
        logic [15:0] p;
        a[0] = 1'b0;
        m = {mem[a + 18'd1], mem[a]};
        rop = a[17] ? cfg.single_page_setup[15:8] : cfg.single_page_setup[7:0];
        p = a[17] ? cfg.single_page_setup[47:32] : cfg.single_page_setup[31:16];
        return choose(cfg.single_write_mode, rop, p, d, m);
    endfunction

    function logic [17:0] plane_addr(logic [17:0] a, int i);
        logic [17:0] off;
        off = {3'b000, a[14:0]};
        off[15] = cfg.access_control[2];
        off[17:16] = i[1:0];
        return off;
    endfunction

    function void put_byte(logic [17:0] a, logic [7:0] v);
        logic [15:0] w;
        logic [17:0] pa;
        logic [7:0]  m;
        if (cfg.access_control[0]) begin
            if (a[0]) begin
                w = page_word(a, {v, 8'h00});
                mem[a] = w[15:8];
            end else begin
                w = page_word(a, {8'h00, v});
                mem[a] = w[7:0];
            end
        end else if (cfg.access_control[1]) begin
            for (int i = 0; i < 4; i++) begin
                if (!cfg.plane_masks[i]) begin
                    pa = plane_addr(a, i);
                    m = mem[pa];
                    w = choose(cfg.advanced_mode[4:3], cfg.plane_rops[i*8 +: 8],
                               {8'h00, pats[i*2 + rd_sel[i]]}, {8'h00, v}, {8'h00, m});
                    mem[pa] = w[7:0];
                    if (cfg.advanced_mode[1]) pats[i*2 + wr_sel[i]] = m;
                end
            end
            if (cfg.advanced_mode[2]) begin
                rd_sel = ~rd_sel;
                if (cfg.advanced_mode[1]) wr_sel = ~wr_sel;
            end
        end else begin
            mem[a] = v;
        end
    endfunction

    function logic [7:0] get_byte(logic [17:0] a);
        logic [7:0]  r;
        logic [7:0]  d;
        if (cfg.access_control[0] || !cfg.access_control[1]) return mem[a];
        r = 8'hff;
        for (int i = 0; i < 4; i++) begin
            if (!cfg.plane_masks[4 + i]) begin
                d = mem[plane_addr(a, i)];
                if (cfg.advanced_mode[5]) r &= ~(d ^ cfg.compare_data[i*8 +: 8]);
                else r &= d;
                if (cfg.advanced_mode[0]) pats[i*2 + wr_sel[i]] = d;
            end
        end
        if (cfg.advanced_mode[2] && cfg.advanced_mode[0]) wr_sel = ~wr_sel;
        return r;
    endfunction

    // Note one accepted input beat and queue its predicted result
    function void note_input(pvram_pkg::in_beat_t b);
        pvram_pkg::out_beat_t o;
        logic [3:0]  wr;
        logic [3:0]  rd;
        logic [15:0] v;
        logic [17:0] a;
        a = b.address;
        wr = cfg.access_control[0] ? 4'd1 : 4'd4;
        rd = cfg.access_control[0] ? 4'd4 : 4'd7;
        o = '0;
        case (pvram_pkg::cmd_t'(b.command))
            pvram_pkg::CMD_BYTE_READ: begin
                o.wait_cycles = rd;
                o.read_data = {8'h00, get_byte(a)};
            end
            pvram_pkg::CMD_BYTE_WRITE: begin
                o.wait_cycles = wr;
                put_byte(a, b.write_data[7:0]);
            end
            pvram_pkg::CMD_WORD_READ: begin
                o.wait_cycles = rd;
                o.read_data[7:0] = get_byte(a);
                o.read_data[15:8] = get_byte(a + 18'd1);
            end
            default: begin
                if (a[0]) begin
                    o.wait_cycles = wr * 2;
                    put_byte(a, b.write_data[7:0]);
                    put_byte(a + 18'd1, b.write_data[15:8]);
                end else if (cfg.access_control[0]) begin
                    o.wait_cycles = wr;
                    v = page_word(a, b.write_data);
                    mem[a] = v[7:0];
                    mem[a + 18'd1] = v[15:8];
                end else begin
                    o.wait_cycles = wr;
                    put_byte(a, b.write_data[7:0]);
                    put_byte(a + 18'd1, b.write_data[15:8]);
                end
            end
        endcase
        pending.push_back(o);
    endfunction

    function void check_result(pvram_pkg::out_beat_t got);
        pvram_pkg::out_beat_t want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                     got.read_data);
            errors++;
        end
        if (got.wait_cycles !== want.wait_cycles) begin
            $display("%0t: wait_cycles expected %0d actual %0d", $time,
                     want.wait_cycles, got.wait_cycles);
            errors++;
        end
    endfunction
endclass

module tb_planar_vram_raster_op_access_core;
    import pvram_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_beat_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_beat_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    vram_scoreboard sb;
    longint cycles;
    int     hold_off;
    bit     stall_random;

    planar_vram_raster_op_access_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: bounds the whole run, clearing pass and all phases, with wide margin
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000) begin
            $display("FAIL planar_vram_raster_op_access_core");
            $finish;
        end
    end

    // Check each result beat as it is taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    end

    // Receiver stall pattern, with a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_off > 0) begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else if (stall_random) begin
            out_stall <= (cycles[9:8] == 2'b01) ? 1'b0 : ($urandom_range(0, 3) == 0);
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [63:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offer one beat and hold it until taken
    task automatic send_beat(logic [1:0] c, logic [17:0] a, logic [15:0] d);
        in_beat_t b;
        b.command = c;
        b.address = a;
        b.write_data = d;
        in_data <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(b);
        @(negedge clk);
    endtask

    task automatic gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        @(negedge clk);
    endtask

    // Random beats in bursts; addresses mostly in a small window to reuse data
    task automatic random_run(int n);
        int burst;
        logic [17:0] a;
        burst = 0;
        for (int k = 0; k < n; k++) begin
            if (burst == 0) begin
                gap();
                burst = $urandom_range(1, 20);
            end
            a = $urandom_range(0, 3) == 0 ? 18'($urandom) :
                {2'($urandom), 1'($urandom), 15'($urandom_range(0, 31))};
            send_beat(2'($urandom), a, 16'($urandom));
            burst--;
        end
    endtask

    task automatic random_config();
        reg_write(REG_ACCESS_CONTROL, 64'($urandom_range(0, 7)));
        reg_write(REG_PLANE_MASKS, 64'($urandom));
        reg_write(REG_ADVANCED_MODE, 64'($urandom));
        reg_write(REG_SINGLE_WRITE, 64'($urandom_range(0, 3)));
        reg_write(REG_PLANE_ROPS, 64'($urandom));
        reg_write(REG_COMPARE_DATA, 64'($urandom));
        reg_write(REG_PAGE_SETUP, {$urandom, $urandom});
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        hold_off = 0;
        stall_random = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: independent byte access at the edges, wrap of word access
        send_beat(CMD_WORD_WRITE, 18'h3ffff, 16'hffff);
        send_beat(CMD_WORD_READ, 18'h3ffff, 16'h0000);
        send_beat(CMD_BYTE_WRITE, 18'h00000, 16'h00a5);
        send_beat(CMD_WORD_WRITE, 18'h00002, 16'h1234);
        send_beat(CMD_BYTE_READ, 18'h00000, 16'hffff);
        drain();

        // Single-plane: logic unit per page, byte lane merge, odd word write
        reg_write(REG_ACCESS_CONTROL, 64'd1);
        reg_write(REG_PAGE_SETUP, 64'h0000_f0f0_5a5a_96_6c);
        reg_write(REG_SINGLE_WRITE, 64'(SRC_LOGIC));
        send_beat(CMD_BYTE_WRITE, 18'h00001, 16'h003c);
        send_beat(CMD_WORD_WRITE, 18'h20000, 16'hbeef);
        send_beat(CMD_WORD_WRITE, 18'h20003, 16'hcafe);
        send_beat(CMD_WORD_READ, 18'h20002, 16'h0000);
        drain();
        reg_write(REG_SINGLE_WRITE, 64'(SRC_PAT));
        send_beat(CMD_WORD_WRITE, 18'h00010, 16'h0000);
        send_beat(CMD_BYTE_READ, 18'h00011, 16'h0000);
        drain();

        // Extended multi-plane: masks, compare, pattern load and toggling
        reg_write(REG_ACCESS_CONTROL, 64'd6);
        reg_write(REG_PLANE_MASKS, 64'hf0);
        reg_write(REG_PLANE_ROPS, 64'hffffffff);
        reg_write(REG_ADVANCED_MODE, 64'h07);
        send_beat(CMD_BYTE_WRITE, 18'h3ffff, 16'h0011);
        send_beat(CMD_BYTE_READ, 18'h07fff, 16'h0000);
        drain();
        reg_write(REG_PLANE_MASKS, 64'h0a);
        reg_write(REG_COMPARE_DATA, 64'h00ff00ff);
        reg_write(REG_ADVANCED_MODE, 64'hff);
        send_beat(CMD_WORD_WRITE, 18'h00005, 16'h8001);
        send_beat(CMD_WORD_READ, 18'h00005, 16'h0000);
        drain();
        reg_write(REG_ADVANCED_MODE, 64'h0d);
        send_beat(CMD_WORD_READ, 18'h00004, 16'h0000);
        send_beat(CMD_WORD_WRITE, 18'h00004, 16'h7ffe);
        drain();

        // Pressure: long receiver hold-off while beats keep coming
        hold_off = 400;
        random_run(40);
        drain();

        // Random phases across register settings, extremes first
        stall_random = 1'b1;
        reg_write(REG_PLANE_ROPS, 64'h0);
        reg_write(REG_COMPARE_DATA, 64'hffffffff);
        reg_write(REG_PAGE_SETUP, 64'hffff_ffff_ffff);
        reg_write(REG_SINGLE_WRITE, 64'd3);
        reg_write(REG_PLANE_MASKS, 64'hff);
        random_run(100);
        drain();
        for (int ph = 0; ph < 14; ph++) begin
            random_config();
            random_run(130);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS planar_vram_raster_op_access_core");
        else
            $display("FAIL planar_vram_raster_op_access_core");
        $finish;
    end
endmodule

`default_nettype wire
